>>> src/lfu_pkg.sv
// Shared types and default constants for the LFU cache table.
// Used by lfu_cache_table, lfu_table_checker and tb_lfu_cache_table; no dependencies.
`default_nettype none

package lfu_pkg;

    localparam int LFU_ENTRIES    = 16;
    localparam int LFU_KEY_BITS   = 32;
    localparam int LFU_VALUE_BITS = 32;
    localparam int LFU_COUNT_BITS = 16;

    // capacity register
    localparam int             CFG_BITS      = 5;
    localparam logic [CFG_BITS-1:0] CFG_CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        ACT_GET   = 2'd0,
        ACT_PUT   = 2'd1,
        ACT_PEEK  = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_SCAN   = 3'd1,
        S_DECIDE = 3'd2,
        S_UPDATE = 3'd3,
        S_OUT    = 3'd4
    } t_state;

endpackage

`default_nettype wire

>>> src/lfu_cache_table.sv
// LFU cache table top level: sequencer, valid bits, occupancy and capacity register.
// Depends on lfu_pkg and lfu_ram (entry store holding key, value, count, recency rank).
`default_nettype none

// A table of ENTRIES key/value entries that evicts the least frequently used
// entry, the oldest one among equal counts. One request word enters on the
// slave stream (tuser = action: get, put, peek, clear) and one result word
// leaves on the master stream. Requests are handled one at a time: the entry
// RAM is walked once to find the key, the eviction candidate and the first
// free slot, and get hits and puts walk it a second time to rewrite recency
// ranks. Both walks go through the single RAM read port, one entry per cycle.
// The capacity register may be written at any time the block is idle; out of
// reset no clearing pass is needed.
module lfu_cache_table
#(
    parameter int ENTRIES    = lfu_pkg::LFU_ENTRIES,
    parameter int KEY_BITS   = lfu_pkg::LFU_KEY_BITS,
    parameter int VALUE_BITS = lfu_pkg::LFU_VALUE_BITS,
    parameter int COUNT_BITS = lfu_pkg::LFU_COUNT_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // capacity register write
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [lfu_pkg::CFG_BITS-1:0]        i_cfg_data,
    // request stream
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // tdata: key, write_value (from bit 0 up), zero padded to bytes
    input  wire logic [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0] i_s_tdata,
    // tuser: action
    input  wire logic [1:0]                          i_s_tuser,
    // result stream
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // tdata: read_value, use_count_out, evicted_key (from bit 0 up), zero padded
    output logic [((VALUE_BITS+COUNT_BITS+KEY_BITS+7)/8)*8-1:0] o_m_tdata,
    // tuser: hit, evicted
    output logic [1:0]                               o_m_tuser
);

    import lfu_pkg::*;

    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int AGE_W   = $clog2(ENTRIES);
    localparam int OCC_W   = $clog2(ENTRIES + 1);
    localparam int CMP_W   = (OCC_W > CFG_BITS) ? OCC_W : CFG_BITS;
    localparam int OUT_W   = ((VALUE_BITS + COUNT_BITS + KEY_BITS + 7) / 8) * 8;
    localparam int WORD_W  = KEY_BITS + VALUE_BITS + COUNT_BITS + AGE_W;
    // word layout from bit 0: age, count, value, key
    localparam int CNT_LSB = AGE_W;
    localparam int VAL_LSB = AGE_W + COUNT_BITS;
    localparam int KEY_LSB = AGE_W + COUNT_BITS + VALUE_BITS;

    localparam logic [IDX_W:0]      CNT_END = (IDX_W+1)'(ENTRIES);
    localparam logic [CMP_W-1:0]    CAP_MAX = CMP_W'(ENTRIES);
    localparam logic [CMP_W-1:0]    CAP_MIN = CMP_W'(1);
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
    localparam logic [AGE_W-1:0]    AGE_ONE = AGE_W'(1);

    t_state                 r_state, n_state;
    logic [CFG_BITS-1:0]    r_cap, n_cap;
    logic [ENTRIES-1:0]     r_valid, n_valid;
    logic [OCC_W-1:0]       r_occ, n_occ;
    logic [IDX_W:0]         r_cnt, n_cnt;
    logic                   r_pend, n_pend;
    logic [IDX_W-1:0]       r_pidx, n_pidx;

    t_action                r_act, n_act;
    logic [KEY_BITS-1:0]    r_key, n_key;
    logic [VALUE_BITS-1:0]  r_wval, n_wval;

    logic                   r_hit, n_hit;
    logic [IDX_W-1:0]       r_slot, n_slot;
    logic [COUNT_BITS-1:0]  r_hcnt, n_hcnt;
    logic [VALUE_BITS-1:0]  r_hval, n_hval;
    logic [AGE_W-1:0]       r_hage, n_hage;

    logic                   r_vfound, n_vfound;
    logic [IDX_W-1:0]       r_vidx, n_vidx;
    logic [COUNT_BITS-1:0]  r_vcnt, n_vcnt;
    logic [AGE_W-1:0]       r_vage, n_vage;
    logic [KEY_BITS-1:0]    r_vkey, n_vkey;

    logic                   r_ffound, n_ffound;
    logic [IDX_W-1:0]       r_fidx, n_fidx;

    logic                   r_ev, n_ev;
    logic                   r_ins, n_ins;
    logic [IDX_W-1:0]       r_tgt, n_tgt;
    logic [WORD_W-1:0]      r_tword, n_tword;

    logic                   r_o_hit, n_o_hit;
    logic [VALUE_BITS-1:0]  r_o_rv, n_o_rv;
    logic [COUNT_BITS-1:0]  r_o_cnt, n_o_cnt;
    logic                   r_o_ev, n_o_ev;
    logic [KEY_BITS-1:0]    r_o_evk, n_o_evk;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [WORD_W-1:0]      ram_wdata;
    logic [IDX_W-1:0]       ram_raddr;
    logic [WORD_W-1:0]      ram_rdata;

    logic [AGE_W-1:0]       rd_age;
    logic [COUNT_BITS-1:0]  rd_cnt;
    logic [VALUE_BITS-1:0]  rd_val;
    logic [KEY_BITS-1:0]    rd_key;
    logic [AGE_W-1:0]       new_age;

    logic [CMP_W-1:0]       cap_eff;
    logic                   full;
    logic [COUNT_BITS-1:0]  cnt_sat;
    logic [IDX_W-1:0]       ins_idx;

    lfu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_age = ram_rdata[AGE_W-1:0];
    assign rd_cnt = ram_rdata[CNT_LSB +: COUNT_BITS];
    assign rd_val = ram_rdata[VAL_LSB +: VALUE_BITS];
    assign rd_key = ram_rdata[KEY_LSB +: KEY_BITS];

    // clamp capacity into 1..ENTRIES
    always_comb begin
        if (r_cap == '0) begin
            cap_eff = CAP_MIN;
        end else if (CMP_W'(r_cap) > CAP_MAX) begin
            cap_eff = CAP_MAX;
        end else begin
            cap_eff = CMP_W'(r_cap);
        end
    end

    assign full    = CMP_W'(r_occ) >= cap_eff;
    assign cnt_sat = (r_hcnt == '1) ? r_hcnt : r_hcnt + COUNT_ONE;

    // new key lands in the lowest free slot, the victim's slot included
    always_comb begin
        if (full && r_vfound && (!r_ffound || r_vidx < r_fidx)) begin
            ins_idx = r_vidx;
        end else begin
            ins_idx = r_fidx;
        end
    end

    // rank rewrite: a touch ages entries younger than the touched one,
    // an insert ages every survivor, closing the victim's gap first
    always_comb begin
        if (r_ins) begin
            if (r_ev && rd_age > r_vage) begin
                new_age = rd_age;
            end else begin
                new_age = rd_age + AGE_ONE;
            end
        end else if (rd_age < r_hage) begin
            new_age = rd_age + AGE_ONE;
        end else begin
            new_age = rd_age;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cap    = r_cap;
        n_valid  = r_valid;
        n_occ    = r_occ;
        n_cnt    = r_cnt;
        n_pend   = 1'b0;
        n_pidx   = r_cnt[IDX_W-1:0];
        n_act    = r_act;
        n_key    = r_key;
        n_wval   = r_wval;
        n_hit    = r_hit;
        n_slot   = r_slot;
        n_hcnt   = r_hcnt;
        n_hval   = r_hval;
        n_hage   = r_hage;
        n_vfound = r_vfound;
        n_vidx   = r_vidx;
        n_vcnt   = r_vcnt;
        n_vage   = r_vage;
        n_vkey   = r_vkey;
        n_ffound = r_ffound;
        n_fidx   = r_fidx;
        n_ev     = r_ev;
        n_ins    = r_ins;
        n_tgt    = r_tgt;
        n_tword  = r_tword;
        n_o_hit  = r_o_hit;
        n_o_rv   = r_o_rv;
        n_o_cnt  = r_o_cnt;
        n_o_ev   = r_o_ev;
        n_o_evk  = r_o_evk;

        ram_we    = 1'b0;
        ram_waddr = r_pidx;
        ram_wdata = ram_rdata;
        ram_raddr = r_cnt[IDX_W-1:0];

        if (i_cfg_valid) begin
            n_cap = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_act    = t_action'(i_s_tuser);
                    n_key    = i_s_tdata[KEY_BITS-1:0];
                    n_wval   = i_s_tdata[KEY_BITS +: VALUE_BITS];
                    n_hit    = 1'b0;
                    n_vfound = 1'b0;
                    n_ffound = 1'b0;
                    n_cnt    = '0;
                    n_state  = S_SCAN;
                end
            end

            S_SCAN: begin
                if (r_cnt < CNT_END) begin
                    n_pend = 1'b1;
                    n_cnt  = r_cnt + 1'b1;
                end
                if (r_pend) begin
                    if (r_valid[r_pidx]) begin
                        if (!r_hit && rd_key == r_key) begin
                            n_hit  = 1'b1;
                            n_slot = r_pidx;
                            n_hcnt = rd_cnt;
                            n_hval = rd_val;
                            n_hage = rd_age;
                        end
                        if (!r_vfound || rd_cnt < r_vcnt ||
                            (rd_cnt == r_vcnt && rd_age > r_vage)) begin
                            n_vfound = 1'b1;
                            n_vidx   = r_pidx;
                            n_vcnt   = rd_cnt;
                            n_vage   = rd_age;
                            n_vkey   = rd_key;
                        end
                    end else if (!r_ffound) begin
                        n_ffound = 1'b1;
                        n_fidx   = r_pidx;
                    end
                end
                if (r_cnt == CNT_END) begin
                    n_state = S_DECIDE;
                end
            end

            S_DECIDE: begin
                n_o_hit = 1'b0;
                n_o_rv  = '0;
                n_o_cnt = '0;
                n_o_ev  = 1'b0;
                n_o_evk = '0;
                n_ev    = 1'b0;
                n_ins   = 1'b0;
                n_cnt   = '0;
                n_state = S_OUT;
                case (r_act)
                    ACT_GET: begin
                        if (r_hit) begin
                            n_o_hit = 1'b1;
                            n_o_rv  = r_hval;
                            n_o_cnt = cnt_sat;
                            n_tgt   = r_slot;
                            n_tword = {r_key, r_hval, cnt_sat, AGE_W'(0)};
                            n_state = S_UPDATE;
                        end
                    end
                    ACT_PEEK: begin
                        if (r_hit) begin
                            n_o_hit = 1'b1;
                            n_o_cnt = r_hcnt;
                        end
                    end
                    ACT_PUT: begin
                        if (r_hit) begin
                            n_o_hit = 1'b1;
                            n_o_cnt = cnt_sat;
                            n_tgt   = r_slot;
                            n_tword = {r_key, r_wval, cnt_sat, AGE_W'(0)};
                            n_state = S_UPDATE;
                        end else begin
                            n_ins   = 1'b1;
                            n_tgt   = ins_idx;
                            n_tword = {r_key, r_wval, COUNT_ONE, AGE_W'(0)};
                            n_state = S_UPDATE;
                            if (full && r_vfound) begin
                                // occupancy holds: one out, one in
                                n_ev             = 1'b1;
                                n_o_ev           = 1'b1;
                                n_o_evk          = r_vkey;
                                n_valid[r_vidx]  = 1'b0;
                            end else begin
                                n_occ = r_occ + 1'b1;
                            end
                            n_valid[ins_idx] = 1'b1;
                        end
                    end
                    ACT_CLEAR: begin
                        n_valid = '0;
                        n_occ   = '0;
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end

            S_UPDATE: begin
                if (r_cnt < CNT_END) begin
                    n_pend = 1'b1;
                    n_cnt  = r_cnt + 1'b1;
                end
                if (r_pend) begin
                    if (r_pidx == r_tgt) begin
                        ram_we    = 1'b1;
                        ram_wdata = r_tword;
                    end else if (r_valid[r_pidx]) begin
                        ram_we    = 1'b1;
                        ram_wdata = {rd_key, rd_val, rd_cnt, new_age};
                    end
                end
                if (r_cnt == CNT_END) begin
                    n_state = S_OUT;
                end
            end

            S_OUT: begin
                if (i_m_tready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cap   <= CFG_CAP_RESET;
            r_valid <= '0;
            r_occ   <= '0;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cap   <= n_cap;
            r_valid <= n_valid;
            r_occ   <= n_occ;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx   <= n_pidx;
        r_act    <= n_act;
        r_key    <= n_key;
        r_wval   <= n_wval;
        r_hit    <= n_hit;
        r_slot   <= n_slot;
        r_hcnt   <= n_hcnt;
        r_hval   <= n_hval;
        r_hage   <= n_hage;
        r_vfound <= n_vfound;
        r_vidx   <= n_vidx;
        r_vcnt   <= n_vcnt;
        r_vage   <= n_vage;
        r_vkey   <= n_vkey;
        r_ffound <= n_ffound;
        r_fidx   <= n_fidx;
        r_ev     <= n_ev;
        r_ins    <= n_ins;
        r_tgt    <= n_tgt;
        r_tword  <= n_tword;
        r_o_hit  <= n_o_hit;
        r_o_rv   <= n_o_rv;
        r_o_cnt  <= n_o_cnt;
        r_o_ev   <= n_o_ev;
        r_o_evk  <= n_o_evk;
    end

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = (r_state == S_OUT);
    assign o_m_tdata   = OUT_W'({r_o_evk, r_o_cnt, r_o_rv});
    assign o_m_tuser   = {r_o_ev, r_o_hit};

endmodule

`default_nettype wire

>>> src/lfu_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependency.
`default_nettype none

module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> sim/lfu_table_checker.sv
// Result checker for lfu_cache_table: tracks the table contents from the accepted
// request and capacity words and compares every result word field by field.
// Depends on lfu_pkg for the action codes, table sizes and capacity reset value.
module lfu_table_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [lfu_pkg::CFG_BITS-1:0] i_cfg_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // tdata: key, write_value (from bit 0 up)
    input  logic [((lfu_pkg::LFU_KEY_BITS+lfu_pkg::LFU_VALUE_BITS+7)/8)*8-1:0] i_s_tdata,
    // tuser: action
    input  logic [1:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // tdata: read_value, use_count_out, evicted_key (from bit 0 up)
    input  logic [((lfu_pkg::LFU_VALUE_BITS+lfu_pkg::LFU_COUNT_BITS+lfu_pkg::LFU_KEY_BITS+7)/8)*8-1:0]
                        i_m_tdata,
    // tuser: hit, evicted
    input  logic [1:0]  i_m_tuser,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import lfu_pkg::*;

    localparam int ENTRIES = LFU_ENTRIES;
    localparam int KB = LFU_KEY_BITS;
    localparam int VB = LFU_VALUE_BITS;
    localparam int CB = LFU_COUNT_BITS;
    localparam int MAX_PRINTED = 100;

    typedef struct packed {
        logic          hit;
        logic [VB-1:0] read_value;
        logic [CB-1:0] use_count;
        logic          evicted;
        logic [KB-1:0] evicted_key;
    } t_lookup_result;

    // mirror of the table
    bit            slot_valid [ENTRIES];
    logic [KB-1:0] slot_key   [ENTRIES];
    logic [VB-1:0] slot_value [ENTRIES];
    logic [CB-1:0] slot_uses  [ENTRIES];
    int unsigned   slot_rank  [ENTRIES];
    int unsigned   occupied;
    logic [CFG_BITS-1:0] capacity;

    t_lookup_result expected_lookups [$];
    int fail_total;

    initial begin
        fail_total   = 0;
        occupied     = 0;
        capacity     = CFG_CAP_RESET;
        foreach (slot_valid[j]) slot_valid[j] = 1'b0;
    end

    task automatic flag_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
        if (fail_total < MAX_PRINTED)
            $display("[%0t] %s: got %0h, expected %0h", $realtime, field, got, want);
        fail_total++;
    endtask

    // Raise the count (saturating) and make the slot the most recent one.
    function automatic void count_use(int s);
        int unsigned was;
        if (slot_uses[s] != '1)
            slot_uses[s]++;
        was = slot_rank[s];
        for (int j = 0; j < ENTRIES; j++)
            if (slot_valid[j] && j != s && slot_rank[j] < was)
                slot_rank[j]++;
        slot_rank[s] = 0;
    endfunction

    function automatic t_lookup_result serve_request(t_action act, logic [KB-1:0] key,
                                                     logic [VB-1:0] wval);
        t_lookup_result r;
        int slot, victim, free_slot;
        int unsigned limit, gap_rank;
        r         = '0;
        slot      = -1;
        victim    = -1;
        free_slot = -1;
        limit     = (capacity == 0) ? 1 : (capacity > ENTRIES) ? ENTRIES : capacity;
        if (act == ACT_CLEAR) begin
            foreach (slot_valid[j]) slot_valid[j] = 1'b0;
            occupied = 0;
            return r;
        end
        for (int j = 0; j < ENTRIES; j++)
            if (slot < 0 && slot_valid[j] && slot_key[j] == key)
                slot = j;
        case (act)
            ACT_GET: begin
                if (slot >= 0) begin
                    count_use(slot);
                    r.hit        = 1'b1;
                    r.read_value = slot_value[slot];
                    r.use_count  = slot_uses[slot];
                end
            end
            ACT_PEEK: begin
                if (slot >= 0) begin
                    r.hit       = 1'b1;
                    r.use_count = slot_uses[slot];
                end
            end
            default: begin
                if (slot >= 0) begin
                    slot_value[slot] = wval;
                    count_use(slot);
                    r.hit       = 1'b1;
                    r.use_count = slot_uses[slot];
                end else begin
                    if (occupied >= limit) begin
                        // lowest count first, oldest touch among equal counts
                        for (int j = 0; j < ENTRIES; j++) begin
                            if (!slot_valid[j])
                                continue;
                            if (victim < 0 || slot_uses[j] < slot_uses[victim] ||
                                (slot_uses[j] == slot_uses[victim] &&
                                 slot_rank[j] > slot_rank[victim]))
                                victim = j;
                        end
                        if (victim >= 0) begin
                            r.evicted     = 1'b1;
                            r.evicted_key = slot_key[victim];
                            gap_rank = slot_rank[victim];
                            slot_valid[victim] = 1'b0;
                            for (int j = 0; j < ENTRIES; j++)
                                if (slot_valid[j] && slot_rank[j] > gap_rank)
                                    slot_rank[j]--;
                            if (occupied > 0)
                                occupied--;
                        end
                    end
                    for (int j = ENTRIES - 1; j >= 0; j--)
                        if (!slot_valid[j])
                            free_slot = j;
                    if (free_slot >= 0) begin
                        for (int j = 0; j < ENTRIES; j++)
                            if (slot_valid[j])
                                slot_rank[j]++;
                        slot_valid[free_slot] = 1'b1;
                        slot_key[free_slot]   = key;
                        slot_value[free_slot] = wval;
                        slot_uses[free_slot]  = 1;
                        slot_rank[free_slot]  = 0;
                        occupied++;
                    end
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_lookup_result got, want;
        if (!i_rst_n) begin
            foreach (slot_valid[j]) slot_valid[j] = 1'b0;
            occupied = 0;
            capacity = CFG_CAP_RESET;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.hit         = i_m_tuser[0];
                got.evicted     = i_m_tuser[1];
                got.read_value  = i_m_tdata[VB-1:0];
                got.use_count   = i_m_tdata[VB +: CB];
                got.evicted_key = i_m_tdata[VB+CB +: KB];
                if (expected_lookups.size() == 0) begin
                    flag_mismatch("result word with nothing pending",
                                  64'(got.evicted_key), 64'd0);
                end else begin
                    want = expected_lookups.pop_front();
                    if (got.hit !== want.hit)
                        flag_mismatch("hit", 64'(got.hit), 64'(want.hit));
                    if (got.read_value !== want.read_value)
                        flag_mismatch("read_value", 64'(got.read_value),
                                      64'(want.read_value));
                    if (got.use_count !== want.use_count)
                        flag_mismatch("use_count_out", 64'(got.use_count),
                                      64'(want.use_count));
                    if (got.evicted !== want.evicted)
                        flag_mismatch("evicted", 64'(got.evicted), 64'(want.evicted));
                    if (got.evicted_key !== want.evicted_key)
                        flag_mismatch("evicted_key", 64'(got.evicted_key),
                                      64'(want.evicted_key));
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                capacity = i_cfg_data;
            if (i_s_tvalid && i_s_tready)
                expected_lookups.push_back(serve_request(t_action'(i_s_tuser),
                                                         i_s_tdata[KB-1:0],
                                                         i_s_tdata[KB +: VB]));
        end
        o_pending    <= expected_lookups.size();
        o_fail_count <= fail_total;
    end

endmodule

>>> sim/tb_lfu_cache_table.sv
// Testbench top for lfu_cache_table: drives requests and capacity writes with random
// gaps and result back-pressure; lfu_table_checker predicts and compares the results.
// Depends on lfu_pkg, lfu_cache_table and lfu_table_checker.
module tb_lfu_cache_table;
    timeunit 1ns;
    timeprecision 1ps;

    import lfu_pkg::*;

    localparam int KB = LFU_KEY_BITS;
    localparam int VB = LFU_VALUE_BITS;
    localparam int CB = LFU_COUNT_BITS;
    localparam int S_W = ((KB + VB + 7) / 8) * 8;
    localparam int M_W = ((VB + CB + KB + 7) / 8) * 8;
    localparam int PHASES = 10;
    localparam int PHASE_ITEMS = 143;
    localparam int KEY_POOL = 24;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           cfg_valid = 1'b0;
    logic [CFG_BITS-1:0] cfg_data = '0;
    logic           s_tvalid = 1'b0;
    logic [S_W-1:0] s_tdata = '0;
    logic [1:0]     s_tuser = ACT_GET;
    logic           m_tready = 1'b0;
    logic           o_cfg_ready;
    logic           o_s_tready;
    logic           o_m_tvalid;
    logic [M_W-1:0] o_m_tdata;
    logic [1:0]     o_m_tuser;
    int             fail_count;
    int             pending;

    bit             hold_results = 1'b0;
    bit             steady_sender = 1'b0;
    int             burst_left = 0;
    logic [KB-1:0]  key_pool [KEY_POOL];

    lfu_cache_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    lfu_table_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Offer one request word; bursts of random length, random gaps between them.
    task automatic issue_request(input t_action act, input logic [KB-1:0] key,
                                 input logic [VB-1:0] wval);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = steady_sender ? 0 : $urandom_range(0, 40);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {wval, key};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // Stop offering and hold until every result word is back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CFG_BITS-1:0] cap);
        drain_results();
        repeat (4) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_request();
        int pick;
        t_action act;
        logic [KB-1:0] key;
        pick = $urandom_range(0, 99);
        if (pick < 40)      act = ACT_GET;
        else if (pick < 82) act = ACT_PUT;
        else if (pick < 99) act = ACT_PEEK;
        else                act = ACT_CLEAR;
        // mostly reuse a small key set so hits and evictions are common
        if ($urandom_range(0, 99) < 85)
            key = key_pool[$urandom_range(0, KEY_POOL - 1)];
        else
            key = $urandom;
        issue_request(act, key, $urandom);
    endtask

    // result back-pressure: its own pattern, plus the long hold-off on request
    initial begin
        int mode, left;
        mode = 0;
        left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_results) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_results = 1'b0;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(20, 200);
                end
                left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ((left / 8) % 2 == 0);
                endcase
            end
        end
    end

    // end the run when no word moves on any channel for too long
    initial begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready) ||
                (cfg_valid && o_cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        logic [CFG_BITS-1:0] cap_plan [PHASES];
        cap_plan = '{5'd1, 5'd0, 5'd31, 5'd16, 5'd2, 5'd17, 5'd5, 5'd16, 5'd3, 5'd8};
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL; i++)
            key_pool[i] = $urandom;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: misses on an empty table, extreme keys and values, update,
        // fill to capacity, one eviction, clear, miss after clear
        steady_sender = 1'b1;
        issue_request(ACT_GET, '0, '0);
        issue_request(ACT_PEEK, '1, '0);
        issue_request(ACT_PUT, '0, '0);
        issue_request(ACT_PUT, '1, '1);
        issue_request(ACT_GET, '1, '0);
        issue_request(ACT_PEEK, '0, '0);
        issue_request(ACT_PUT, '0, 32'h5A5A_A5A5);
        for (int i = 0; i < 14; i++)
            issue_request(ACT_PUT, 32'h0101_0000 * (i + 1) + i, $urandom);
        issue_request(ACT_PUT, 32'h8000_0001, 32'h0000_0001);
        issue_request(ACT_GET, 32'h0101_0000 * 2 + 1, '0);
        issue_request(ACT_CLEAR, '1, '1);
        issue_request(ACT_GET, '0, '0);

        for (int p = 0; p < PHASES; p++) begin
            write_capacity(cap_plan[p]);
            steady_sender = (p % 4 == 1);
            // hold results back while requests keep coming
            if (p == 2 || p == 7)
                hold_results = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2 && p % 3 == 0)
                    drain_results();
                random_request();
            end
        end

        drain_results();
        repeat (2 * LFU_ENTRIES + 8) @(posedge i_clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> sim.f
src/lfu_pkg.sv
src/lfu_ram.sv
src/lfu_cache_table.sv
sim/lfu_table_checker.sv
sim/tb_lfu_cache_table.sv
